// ===== sv/assert_macros.svh =====
// Assertion macros for the concurrent checks of the nearest point search.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest point search: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest point search: next-cycle check failed");

`endif

// ===== sv/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Types and codes shared by the nearest point search cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    localparam int COORD_W = 12;
    localparam int LAYER_W = 3;
    localparam int IDENT_W = 8;
    localparam int SLOT_W  = 3;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int COUNT_W = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDENT_W-1:0] ident;
    } entry_t;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } query_t;

    // Running best match, handed from cell to cell during a scan.
    typedef struct packed {
        logic               have;
        logic [SLOT_W-1:0]  slot;
        logic [DIST_W-1:0]  distance;
        logic [IDENT_W-1:0] ident;
    } search_rec_t;

    localparam search_rec_t SEARCH_SEED = '0;

endpackage

`default_nettype wire

// ===== sv/nps_cell.sv =====
// ----------------------------------------------------------------------------
// nps_cell
// One table slot: stores a point, works out its squared distance to the
// held query point and updates the running best match as it passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_cell #(
    parameter int unsigned SLOT = 0
) (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [nps_pkg::SLOT_W-1:0]          wr_index,
    input  wire nps_pkg::entry_t                     wr_entry,
    input  wire nps_pkg::query_t                     query,
    input  wire logic [nps_pkg::COUNT_W-1:0]         active_count,
    input  wire logic                                scan_en,
    input  wire nps_pkg::search_rec_t                rec_in,
    output nps_pkg::search_rec_t                     rec_out
);

    localparam logic [nps_pkg::SLOT_W-1:0] SLOT_BITS = nps_pkg::SLOT_W'(SLOT);

    nps_pkg::entry_t             entry_reg;
    logic [nps_pkg::COORD_W-1:0] dx;
    logic [nps_pkg::COORD_W-1:0] dy;
    logic [nps_pkg::SQ_W-1:0]    sq_x_reg;
    logic [nps_pkg::SQ_W-1:0]    sq_y_reg;
    logic [nps_pkg::DIST_W-1:0]  dist_reg;
    logic                        layer_ok_reg;
    logic                        active;
    logic                        take;
    nps_pkg::search_rec_t        rec_reg;
    nps_pkg::search_rec_t        rec_next;

    always_ff @(posedge clk)
    begin
        if (wr_en && (int'(wr_index) == SLOT))
        begin
            entry_reg <= wr_entry;
        end
    end

    assign dx = (entry_reg.x >= query.x) ? (entry_reg.x - query.x) : (query.x - entry_reg.x);
    assign dy = (entry_reg.y >= query.y) ? (entry_reg.y - query.y) : (query.y - entry_reg.y);

    // Squares first, then their sum, so each stage holds one operation.
    always_ff @(posedge clk)
    begin
        sq_x_reg     <= dx * dx;
        sq_y_reg     <= dy * dy;
        dist_reg     <= {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
        layer_ok_reg <= (entry_reg.layer == query.layer);
    end

    assign active = layer_ok_reg && (int'(active_count) > SLOT);

    assign take = active && (!rec_in.have || (dist_reg < rec_in.distance) ||
                  ((dist_reg == rec_in.distance) && (entry_reg.ident < rec_in.ident)));

    always_comb
    begin
        rec_next = rec_in;
        if (take)
        begin
            rec_next.have     = 1'b1;
            rec_next.slot     = SLOT_BITS;
            rec_next.distance = dist_reg;
            rec_next.ident    = entry_reg.ident;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_en)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;

endmodule

`default_nettype wire

// ===== sv/nearest_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search
// Table of points with a nearest-neighbour query by squared distance.
//
// Usage: one input channel (in_valid/in_ready) carries both kinds of item.
// A write (opcode 0) stores a point in slot entry_index and gives no result.
// A query (opcode 1) walks a search record along a row of cells, one cell
// per table slot and one slot per cycle, and gives exactly one transfer on
// the output channel (out_valid/out_ready) with found and nearest_index.
// After its transfer a query passes the distance stages in every cell
// (squares, then their sum), then the walk, whose last step lets the record
// settle in the final cell. The input is not ready while a query is in
// flight, so a new query is taken only once the last one has left the row;
// writes are taken one per cycle while no query is in flight. A finished
// result waits in the output register, and when the receiver stalls the
// next query holds at the end of its walk until the register is free.
// active_count is written through the cfg channel, which is always ready;
// the user must write it only while the block is idle, and the block itself
// does not enforce this. Reset clears the sequencer, the output valid flag
// and active_count to zero; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nearest_point_search #(
    parameter int TABLE_DEPTH = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nps_pkg::COUNT_W-1:0]       cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              opcode,
    input  wire logic [nps_pkg::SLOT_W-1:0]        entry_index,
    input  wire logic [nps_pkg::LAYER_W-1:0]       entry_layer,
    input  wire logic [nps_pkg::COORD_W-1:0]       entry_x,
    input  wire logic [nps_pkg::COORD_W-1:0]       entry_y,
    input  wire logic [nps_pkg::IDENT_W-1:0]       entry_ident,
    input  wire logic [nps_pkg::LAYER_W-1:0]       query_layer,
    input  wire logic [nps_pkg::COORD_W-1:0]       query_x,
    input  wire logic [nps_pkg::COORD_W-1:0]       query_y,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   found,
    output logic [nps_pkg::SLOT_W-1:0]             nearest_index
);

    // Counter for the walk along the row of cells. It runs one step past the
    // last cell, so that the final cell's record is settled when it is read.
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH);

    // Sequencer codes.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_DIST = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    logic [nps_pkg::COUNT_W-1:0]       active_count_reg;
    nps_pkg::query_t                   query_reg;
    nps_pkg::entry_t                   wr_entry;
    logic                              in_xfer;
    logic                              wr_en;
    logic                              scan_en;
    logic                              walk_end;
    logic                              load_out;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              found_reg;
    logic [nps_pkg::SLOT_W-1:0]        index_reg;
    nps_pkg::search_rec_t              chain [TABLE_DEPTH];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign wr_en     = in_xfer && (opcode == nps_pkg::OP_WRITE);
    assign scan_en   = (state_reg == ST_SCAN);
    assign walk_end  = scan_en && (cnt_reg == CNT_LAST);

    // The result leaves the row once the output register is free.
    assign load_out  = (walk_end || (state_reg == ST_DONE)) && (!out_valid_reg || out_ready);

    assign wr_entry.layer = entry_layer;
    assign wr_entry.x     = entry_x;
    assign wr_entry.y     = entry_y;
    assign wr_entry.ident = entry_ident;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_count_reg <= cfg_data;
        end
    end

    // The query point is held for the whole walk and seen by every cell.
    always_ff @(posedge clk)
    begin
        if (in_xfer && (opcode == nps_pkg::OP_QUERY))
        begin
            query_reg.layer <= query_layer;
            query_reg.x     <= query_x;
            query_reg.y     <= query_y;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (opcode == nps_pkg::OP_QUERY))
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                state_next = ST_SCAN;
                cnt_next   = '0;
            end
            ST_SCAN:
            begin
                if (walk_end)
                begin
                    state_next = load_out ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Row of cells: cell 0 starts from an empty record, each later cell
    // takes its neighbour's registered record as its starting point.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        nps_pkg::search_rec_t rec_in;

        if (g == 0)
        begin : g_head
            assign rec_in = nps_pkg::SEARCH_SEED;
        end
        else
        begin : g_link
            assign rec_in = chain[g-1];
        end

        nps_cell #(
            .SLOT (g)
        ) u_cell (
            .clk          (clk),
            .wr_en        (wr_en),
            .wr_index     (entry_index),
            .wr_entry     (wr_entry),
            .query        (query_reg),
            .active_count (active_count_reg),
            .scan_en      (scan_en),
            .rec_in       (rec_in),
            .rec_out      (chain[g])
        );
    end

    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg <= chain[TABLE_DEPTH-1].have;
            index_reg <= chain[TABLE_DEPTH-1].have ? chain[TABLE_DEPTH-1].slot : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign nearest_index = index_reg;

    // A query transfer always starts the distance stages.
    `NPS_ASSERT_NEXT(a_query_starts, in_xfer && (opcode == nps_pkg::OP_QUERY), state_reg == ST_SQ)
    // A result that reports no match carries slot zero.
    `NPS_ASSERT_NOW(a_empty_index, out_valid && !found, nearest_index == '0)
    // The end of a walk either delivers the result or waits for the receiver.
    `NPS_ASSERT_NEXT(a_walk_end, walk_end, out_valid_reg && ((state_reg == ST_IDLE) || (state_reg == ST_DONE)))
    // While a result waits, no new one may overwrite it.
    `NPS_ASSERT_NOW(a_no_overwrite, load_out, !out_valid_reg || out_ready)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the nearest point search block.
//
// The bench keeps its own copy of the point table and of active_count. It
// works out the expected answer to every query at the moment the query is
// transferred into the block, and queues that answer. Each result transfer is
// then compared, field by field, with the oldest queued answer.
//
// The stimulus starts with a short directed plan. The plan is a list of rows
// walked by a loop. It covers a query on an empty search, every slot written,
// some with extreme values, distance ties broken by identifier, a tie on both
// distance and identifier, a count above the table depth and a count of
// zero. Random phases follow, each one opened by an active_count write while
// the block is idle. The sender works in bursts and the receiver stalls on
// its own pattern. One long receiver hold-off lets the block fill up, so that
// it has to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH           = 8;
    // Longer than a query's path through the block while the receiver keeps up.
    localparam int IDLE_GAP        = DEPTH + 8;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_PHASE      = 4;
    localparam int DRAIN_LIMIT     = 20000;

    // One item on the input channel. Every port is carried, whichever kind of
    // item it is, so that the unused fields can carry noise.
    typedef struct {
        logic                        op;
        logic [nps_pkg::SLOT_W-1:0]  slot;
        logic [nps_pkg::LAYER_W-1:0] e_layer;
        logic [nps_pkg::COORD_W-1:0] e_x;
        logic [nps_pkg::COORD_W-1:0] e_y;
        logic [nps_pkg::IDENT_W-1:0] e_ident;
        logic [nps_pkg::LAYER_W-1:0] q_layer;
        logic [nps_pkg::COORD_W-1:0] q_x;
        logic [nps_pkg::COORD_W-1:0] q_y;
    } point_item_t;

    // Answer to one query.
    typedef struct {
        logic                       found;
        logic [nps_pkg::SLOT_W-1:0] slot;
    } match_t;

    typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

    // A row of the directed plan. Where typed is set, the answer in want is
    // the one that is checked, rather than the answer from the predictor.
    typedef struct {
        row_kind_t                   kind;
        point_item_t                 item;
        logic [nps_pkg::COUNT_W-1:0] count;
        bit                          typed;
        match_t                      want;
    } plan_row_t;

    // The clock and every block input are known from time zero.
    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [nps_pkg::COUNT_W-1:0] cfg_data      = '0;
    logic                        in_valid      = 1'b0;
    logic                        in_ready;
    logic                        opcode        = nps_pkg::OP_WRITE;
    logic [nps_pkg::SLOT_W-1:0]  entry_index   = '0;
    logic [nps_pkg::LAYER_W-1:0] entry_layer   = '0;
    logic [nps_pkg::COORD_W-1:0] entry_x       = '0;
    logic [nps_pkg::COORD_W-1:0] entry_y       = '0;
    logic [nps_pkg::IDENT_W-1:0] entry_ident   = '0;
    logic [nps_pkg::LAYER_W-1:0] query_layer   = '0;
    logic [nps_pkg::COORD_W-1:0] query_x       = '0;
    logic [nps_pkg::COORD_W-1:0] query_y       = '0;
    logic                        out_valid;
    logic                        out_ready     = 1'b0;
    logic                        found;
    logic [nps_pkg::SLOT_W-1:0]  nearest_index;

    // The bench's own copy of the table and of the search count.
    logic [nps_pkg::LAYER_W-1:0] tbl_layer [DEPTH];
    logic [nps_pkg::COORD_W-1:0] tbl_x     [DEPTH];
    logic [nps_pkg::COORD_W-1:0] tbl_y     [DEPTH];
    logic [nps_pkg::IDENT_W-1:0] tbl_ident [DEPTH];
    logic [nps_pkg::COUNT_W-1:0] tbl_count = '0;

    // Answers still waiting for their result transfer, oldest first.
    match_t match_queue [$];
    int     error_count  = 0;
    bit     hold_request = 1'b0;

    nearest_point_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .entry_layer  (entry_layer),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .entry_ident  (entry_ident),
        .query_layer  (query_layer),
        .query_x      (query_x),
        .query_y      (query_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .nearest_index(nearest_index)
    );

    always #1 clk = ~clk;

    // Ends the run if the block hangs. The figure is several times the
    // slowest legal run.
    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Predictor. The search covers slots 0 to active_count-1, and a count
    // above the table depth covers the whole table. Entries on another layer
    // are skipped. A strictly smaller squared distance wins. On an equal
    // distance the smaller identifier wins. On an equal distance and an equal
    // identifier the earlier slot stays.
    function automatic match_t nearest_match(input logic [nps_pkg::LAYER_W-1:0] layer,
                                             input logic [nps_pkg::COORD_W-1:0] qx,
                                             input logic [nps_pkg::COORD_W-1:0] qy);
        match_t      best;
        int unsigned limit;
        int unsigned dx;
        int unsigned dy;
        int unsigned distance;
        int unsigned best_dist;
        best.found = 1'b0;
        best.slot  = '0;
        best_dist  = 0;
        limit = (int'(tbl_count) > DEPTH) ? DEPTH : int'(tbl_count);
        for (int i = 0; i < limit; i++)
        begin
            if (tbl_layer[i] == layer)
            begin
                dx = (tbl_x[i] >= qx) ? 32'(tbl_x[i] - qx) : 32'(qx - tbl_x[i]);
                dy = (tbl_y[i] >= qy) ? 32'(tbl_y[i] - qy) : 32'(qy - tbl_y[i]);
                distance = dx * dx + dy * dy;
                if (!best.found || distance < best_dist)
                begin
                    best.found = 1'b1;
                    best.slot  = i[nps_pkg::SLOT_W-1:0];
                    best_dist  = distance;
                end
                else if (distance == best_dist && tbl_ident[i] < tbl_ident[best.slot])
                begin
                    best.slot = i[nps_pkg::SLOT_W-1:0];
                end
            end
        end
        return best;
    endfunction

    // Offers one item and holds it until its transfer. The predictor is
    // updated at that same edge. Valid is left high: the caller lowers it
    // only when a gap follows, so that it is never lowered and raised again
    // at the same edge.
    task automatic offer_item(input point_item_t item, input bit typed,
                              input match_t want);
        in_valid    <= 1'b1;
        opcode      <= item.op;
        entry_index <= item.slot;
        entry_layer <= item.e_layer;
        entry_x     <= item.e_x;
        entry_y     <= item.e_y;
        entry_ident <= item.e_ident;
        query_layer <= item.q_layer;
        query_x     <= item.q_x;
        query_y     <= item.q_y;
        do
            @(posedge clk);
        while (!in_ready);
        if (item.op == nps_pkg::OP_WRITE)
        begin
            tbl_layer[item.slot] = item.e_layer;
            tbl_x[item.slot]     = item.e_x;
            tbl_y[item.slot]     = item.e_y;
            tbl_ident[item.slot] = item.e_ident;
        end
        else
        begin
            match_queue.push_back(typed ? want
                                        : nearest_match(item.q_layer, item.q_x, item.q_y));
        end
    endtask

    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every queued answer has been matched. Then it lets the idle
    // gap pass, since a write gives no result to wait for. Answers left over
    // after the limit are failures.
    task automatic drain_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (match_queue.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (match_queue.size() != 0)
        begin
            report_mismatch("results never delivered", 0, match_queue.size());
            match_queue.delete();
        end
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Writes active_count, only once the block has gone idle.
    task automatic write_count(input logic [nps_pkg::COUNT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_count = value;
    endtask

    function automatic plan_row_t write_row(input logic [nps_pkg::SLOT_W-1:0] slot,
                                            input logic [nps_pkg::LAYER_W-1:0] layer,
                                            input logic [nps_pkg::COORD_W-1:0] x,
                                            input logic [nps_pkg::COORD_W-1:0] y,
                                            input logic [nps_pkg::IDENT_W-1:0] ident);
        plan_row_t row;
        row.kind  = ROW_ITEM;
        row.item  = '{nps_pkg::OP_WRITE, slot, layer, x, y, ident, layer, x, y};
        row.count = '0;
        row.typed = 1'b0;
        row.want  = '{1'b0, '0};
        return row;
    endfunction

    function automatic plan_row_t query_row(input logic [nps_pkg::LAYER_W-1:0] layer,
                                            input logic [nps_pkg::COORD_W-1:0] x,
                                            input logic [nps_pkg::COORD_W-1:0] y,
                                            input bit typed,
                                            input logic hit,
                                            input logic [nps_pkg::SLOT_W-1:0] slot);
        plan_row_t row;
        row.kind  = ROW_ITEM;
        row.item  = '{nps_pkg::OP_QUERY, '0, layer, x, y, '0, layer, x, y};
        row.count = '0;
        row.typed = typed;
        row.want  = '{hit, slot};
        return row;
    endfunction

    function automatic plan_row_t config_row(input logic [nps_pkg::COUNT_W-1:0] value);
        plan_row_t row;
        row      = write_row('0, '0, '0, '0, '0);
        row.kind = ROW_CONFIG;
        row.count = value;
        return row;
    endfunction

    // Coordinates lean towards the extremes and towards a small cluster, so
    // that equal distances come up often.
    function automatic logic [nps_pkg::COORD_W-1:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? '1 : '0;
            1:       return nps_pkg::COORD_W'($urandom_range(0, 7));
            default: return nps_pkg::COORD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Half of the layers are drawn from 0 or 1 alone, so that most queries find a match.
    function automatic logic [nps_pkg::LAYER_W-1:0] random_layer();
        return $urandom_range(0, 1) ? nps_pkg::LAYER_W'($urandom_range(0, 1))
                                    : nps_pkg::LAYER_W'($urandom_range(0, 7));
    endfunction

    function automatic point_item_t random_item();
        point_item_t item;
        item.op      = ($urandom_range(0, 9) < 3) ? nps_pkg::OP_WRITE : nps_pkg::OP_QUERY;
        item.slot    = nps_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
        item.e_layer = random_layer();
        item.e_x     = random_coord();
        item.e_y     = random_coord();
        item.e_ident = $urandom_range(0, 1) ? nps_pkg::IDENT_W'($urandom_range(0, 3))
                                            : nps_pkg::IDENT_W'($urandom_range(0, 255));
        item.q_layer = random_layer();
        item.q_x     = random_coord();
        item.q_y     = random_coord();
        return item;
    endfunction

    // Receiver. It runs in stretches: always ready, ready half of the time,
    // or ready by chance one time in four. When the stimulus asks, it holds off
    // for a long stretch, counted here, while the sender keeps offering items.
    initial
    begin : receiver
        int mode;
        int run_len;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode    = $urandom_range(0, 2);
                run_len = $urandom_range(5, 40);
                repeat (run_len)
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        default: out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Each result transfer is checked against the oldest answer still
    // waiting. The values sampled here are the ones from before the edge.
    always @(posedge clk)
    begin : result_check
        match_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (match_queue.size() == 0)
            begin
                report_mismatch("result with nothing pending", 32'(found), 0);
            end
            else
            begin
                want = match_queue.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 32'(found), 32'(want.found));
                if (nearest_index !== want.slot)
                    report_mismatch("nearest_index", 32'(nearest_index), 32'(want.slot));
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t                   plan [$];
        logic [nps_pkg::COUNT_W-1:0] phase_counts [RANDOM_PHASES];
        match_t                      no_match;
        int                          burst_left;
        int                          gap;

        no_match = '{1'b0, '0};

        // Query on an empty search straight after reset: active_count is 0.
        plan.push_back(query_row(0, 0, 0, 1'b1, 1'b0, 0));
        // Fill every slot. Slots 2 and 3 lie at the same distance from
        // (200,100) and differ in identifier. Slots 4 and 5 lie at the same
        // distance from the origin. Slots 6 and 7 are identical, so the
        // earlier slot must stay.
        plan.push_back(write_row(0, 0, 0, 0, 0));
        plan.push_back(write_row(1, 1, 4095, 4095, 255));
        plan.push_back(write_row(2, 1, 100, 100, 20));
        plan.push_back(write_row(3, 1, 300, 100, 10));
        plan.push_back(write_row(4, 7, 4095, 0, 255));
        plan.push_back(write_row(5, 7, 0, 4095, 128));
        plan.push_back(write_row(6, 2, 50, 50, 5));
        plan.push_back(write_row(7, 2, 50, 50, 5));
        plan.push_back(config_row(DEPTH));
        plan.push_back(query_row(0, 0, 0, 1'b1, 1'b1, 0));
        plan.push_back(query_row(1, 4095, 4095, 1'b1, 1'b1, 1));
        plan.push_back(query_row(1, 200, 100, 1'b0, 1'b0, 0));
        plan.push_back(query_row(7, 0, 0, 1'b0, 1'b0, 0));
        plan.push_back(query_row(2, 50, 50, 1'b0, 1'b0, 0));
        // No entry on layer 3.
        plan.push_back(query_row(3, 2048, 2048, 1'b1, 1'b0, 0));
        plan.push_back(query_row(0, 4095, 4095, 1'b0, 1'b0, 0));
        // A count above the table depth searches the whole table.
        plan.push_back(config_row('1));
        plan.push_back(query_row(7, 4095, 4095, 1'b0, 1'b0, 0));
        plan.push_back(config_row(1));
        plan.push_back(query_row(1, 0, 0, 1'b0, 1'b0, 0));
        plan.push_back(config_row(0));
        plan.push_back(query_row(0, 0, 0, 1'b1, 1'b0, 0));

        // Fixed counts come first, the extremes among them, then random counts,
        // which may lie beyond the table.
        phase_counts[0] = DEPTH;
        phase_counts[1] = 0;
        phase_counts[2] = '1;
        phase_counts[3] = 3;
        phase_counts[4] = DEPTH;
        for (int p = 5; p < RANDOM_PHASES; p++)
            phase_counts[p] = nps_pkg::COUNT_W'($urandom_range(0, 15));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_CONFIG)
                write_count(plan[r].count);
            else
                offer_item(plan[r].item, plan[r].typed, plan[r].want);
        end

        // Every slot has now been written, so random queries never touch an
        // entry that was not written.
        burst_left = 0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_count(phase_counts[p]);
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                        idle_sender(gap);
                    burst_left = $urandom_range(1, 20);
                end
                offer_item(random_item(), 1'b0, no_match);
                burst_left--;
            end
        end

        drain_results();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/nps_pkg.sv
sv/nps_cell.sv
sv/nearest_point_search.sv
sim/tb_top.sv
